FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each check is clocked on aclk and is switched off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define WER_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// When the trigger holds, the result must hold in the next cycle.
`define WER_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/wer_pkg.sv
package wer_pkg;

    // Default input value precision.
    localparam int VALUE_BITS_DEF = 16;

    // Fixed-point layout of the internal arithmetic.
    localparam int FRAC     = 30;
    localparam int LOG_BITS = 28;
    localparam int MUL_W    = 34;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int DIV_W    = 58;
    localparam int DEN_W    = 39;
    localparam int SUM_W    = 40;
    localparam int EXP_W    = 34;
    localparam int K_W      = 6;
    localparam int EXP_MAX_K = 48;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // Configuration registers.
    localparam int ALPHA_W    = 16;
    localparam int BETA_W     = 24;
    localparam int CFG_W      = 24;
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALPHA = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BETA  = 1'b1;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // One classified pair as it waits in the queue.
    typedef struct packed {
        logic [29:0] diff;
        logic [30:0] total;
        logic [15:0] weight;
        logic        last;
    } wer_item_t;

    // Request to the shared divider.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    // Answer from the shared divider.
    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: src/wer_front.sv
module wer_front import wer_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // value_a, value_b, term_weight
    input  logic        s_tlast,   // last_pair
    output logic        push_valid,
    input  logic        push_ready,
    output wer_item_t   push_data
);

    localparam int KEEP  = (VALUE_BITS < 16) ? VALUE_BITS : 16;
    localparam int SHIFT = FRAC - VALUE_BITS;
    localparam logic [15:0] VAL_MASK = 16'((32'h1 << KEEP) - 32'h1);

    logic [45:0] a_ext;
    logic [45:0] b_ext;
    logic [29:0] a_q30;
    logic [29:0] b_q30;

    // Scale both probabilities to Q.30.
    assign a_ext = {30'd0, s_tdata[15:0] & VAL_MASK} << SHIFT;
    assign b_ext = {30'd0, s_tdata[31:16] & VAL_MASK} << SHIFT;
    assign a_q30 = a_ext[29:0];
    assign b_q30 = b_ext[29:0];

    // Form the distance and sum of the pair for the back end.
    assign push_data.diff   = (a_q30 >= b_q30) ? (a_q30 - b_q30) : (b_q30 - a_q30);
    assign push_data.total  = {1'b0, a_q30} + {1'b0, b_q30};
    assign push_data.weight = s_tdata[47:32];
    assign push_data.last   = s_tlast;

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

FILE: src/wer_fifo.sv
`include "assert_macros.svh"

module wer_fifo import wer_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  wer_item_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output wer_item_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    wer_item_t              entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   push;
    logic                   pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Storage and pointers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                entries_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `WER_ASSERT(a_fifo_bound, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
    `WER_ASSERT_NEXT(a_fifo_grow, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not grow")

endmodule

FILE: src/wer_div.sv
`include "assert_macros.svh"

module wer_div import wer_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] dsr_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    // One quotient bit per cycle, restoring form.
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                dsr_reg  <= req.divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? DEN_W'(trial - {1'b0, dsr_reg}) : trial[DEN_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    `WER_ASSERT(a_div_no_restart, !(req.start && busy_reg), "divider started while busy")

endmodule

FILE: src/wer_back.sv
`include "assert_macros.svh"

module wer_back import wer_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  wer_item_t             q_data,
    output div_req_t              div_req,
    input  div_rsp_t              div_rsp,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata    // distance, overflowed
);

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_SQ_MUL, S_SQ_ADJ, S_E_MUL, S_E_CHK, S_Z_MUL, S_Z_DONE,
        S_EXP_MUL, S_EXP_DIV, S_EXP_WAIT, S_Q_MUL, S_Q_DIV, S_Q_WAIT, S_ACC
    } state_t;

    typedef enum logic [1:0] {RET_POW, RET_NUM, RET_DEN} ret_t;

    state_t              state_reg;
    ret_t                ret_reg;
    logic [ALPHA_W-1:0]  alpha_reg;
    logic [BETA_W-1:0]   beta_reg;
    logic [30:0]         total_reg;
    logic [15:0]         w_reg;
    logic                last_reg;
    logic [31:0]         m_reg;
    logic [4:0]          sh_reg;
    logic [4:0]          i_reg;
    logic [LOG_BITS-1:0] f_reg;
    logic [4:0]          n_reg;
    logic [28:0]         t_reg;
    logic [30:0]         x_reg;
    logic [EXP_W-1:0]    eterm_reg;
    logic [EXP_W-1:0]    esum_reg;
    logic [K_W-1:0]      k_reg;
    logic [EXP_W-1:0]    num_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [DIV_W-1:0]    term_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SUM_W-1:0]    running_sum_reg;
    logic                sat_flag_reg;
    logic                m_valid_reg;
    logic [SUM_W-1:0]    out_dist_reg;
    logic                out_ovf_reg;

    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [32:0]         neg;
    logic [36:0]         e_val;
    logic [31:0]         sq;
    logic                exp_zero;
    logic                exp_fin;
    logic [EXP_W-1:0]    esum_new;
    logic [DIV_W:0]      acc_sum;
    logic                acc_ovf;
    logic                out_free;
    logic                emit;

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ_MUL: begin
                mul_a = MUL_W'(m_reg);
                mul_b = MUL_W'(m_reg);
            end
            S_E_MUL: begin
                mul_a = MUL_W'(alpha_reg);
                mul_b = MUL_W'(neg);
            end
            S_Z_MUL: begin
                mul_a = MUL_W'(t_reg);
                mul_b = MUL_W'(LN2_Q30);
            end
            S_EXP_MUL: begin
                mul_a = eterm_reg;
                mul_b = MUL_W'(x_reg);
            end
            S_Q_MUL: begin
                mul_a = MUL_W'(w_reg);
                mul_b = num_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Log and power helpers.
    assign neg   = {sh_reg, {LOG_BITS{1'b0}}} - {5'd0, f_reg};
    assign e_val = prod_reg[48:12];
    assign sq    = prod_reg[61:30];

    // Series step result.
    assign exp_zero = (div_rsp.quotient == '0);
    assign esum_new = exp_zero ? esum_reg : esum_reg + div_rsp.quotient[EXP_W-1:0];
    assign exp_fin  = exp_zero || (k_reg == K_W'(EXP_MAX_K));

    // Saturating accumulate.
    assign acc_sum  = {{(DIV_W - SUM_W + 1){1'b0}}, running_sum_reg} + {1'b0, term_reg};
    assign acc_ovf  = (acc_sum[DIV_W:SUM_W] != '0);
    assign out_free = !m_valid_reg || m_tready;
    assign emit     = (state_reg == S_ACC) && last_reg && out_free;

    // Divider requests.
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (state_reg)
            S_EXP_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(prod_reg[PROD_W-1:FRAC]);
                div_req.divisor  = DEN_W'(k_reg);
            end
            S_Q_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = {prod_reg[49:0], 8'd0} + DIV_W'(den_reg[DEN_W-1:1]);
                div_req.divisor  = den_reg;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    assign q_ready  = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_ovf_reg, out_dist_reg};

    // Sequencer for one pair: power, up to three exponentials, quotient, accumulate.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            alpha_reg       <= ALPHA_W'(4096);
            beta_reg        <= BETA_W'(65536);
            running_sum_reg <= '0;
            sat_flag_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            prod_reg <= mul_a * mul_b;

            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_ALPHA: alpha_reg <= cfg_wdata[ALPHA_W-1:0];
                    CFG_BETA:  beta_reg  <= cfg_wdata[BETA_W-1:0];
                    default:   alpha_reg <= alpha_reg;
                endcase
            end

            // The output word leaves unless a new one replaces it in this cycle.
            if (m_valid_reg && m_tready && !emit) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        total_reg <= q_data.total;
                        w_reg     <= q_data.weight;
                        last_reg  <= q_data.last;
                        m_reg     <= {2'b00, q_data.diff};
                        sh_reg    <= '0;
                        if (alpha_reg == '0 || q_data.diff == '0) begin
                            // Power is one for zero alpha, zero for equal values.
                            x_reg     <= (alpha_reg == '0) ? 31'(32'd1 << FRAC) : '0;
                            esum_reg  <= EXP_W'(64'd1 << FRAC);
                            eterm_reg <= EXP_W'(64'd1 << FRAC);
                            k_reg     <= K_W'(1);
                            ret_reg   <= RET_NUM;
                            state_reg <= S_EXP_MUL;
                        end else begin
                            state_reg <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    // Normalize the difference to [1,2) in Q1.30.
                    if (m_reg[FRAC]) begin
                        i_reg     <= 5'(LOG_BITS - 1);
                        f_reg     <= '0;
                        state_reg <= S_SQ_MUL;
                    end else begin
                        m_reg  <= {m_reg[30:0], 1'b0};
                        sh_reg <= sh_reg + 1'b1;
                    end
                end
                S_SQ_MUL: begin
                    state_reg <= S_SQ_ADJ;
                end
                S_SQ_ADJ: begin
                    // One fraction bit of log2 per squaring.
                    if (sq[31]) begin
                        m_reg <= {1'b0, sq[31:1]};
                        f_reg <= f_reg | (LOG_BITS'(1) << i_reg);
                    end else begin
                        m_reg <= sq;
                    end
                    if (i_reg == '0) begin
                        state_reg <= S_E_MUL;
                    end else begin
                        i_reg     <= i_reg - 1'b1;
                        state_reg <= S_SQ_MUL;
                    end
                end
                S_E_MUL: begin
                    state_reg <= S_E_CHK;
                end
                S_E_CHK: begin
                    n_reg <= e_val[32:28];
                    if (e_val[36:28] > 9'd30) begin
                        x_reg     <= '0;
                        esum_reg  <= EXP_W'(64'd1 << FRAC);
                        eterm_reg <= EXP_W'(64'd1 << FRAC);
                        k_reg     <= K_W'(1);
                        ret_reg   <= RET_NUM;
                        state_reg <= S_EXP_MUL;
                    end else if (e_val[27:0] == '0) begin
                        // Whole power of two.
                        x_reg     <= 31'(32'd1 << FRAC) >> e_val[32:28];
                        esum_reg  <= EXP_W'(64'd1 << FRAC);
                        eterm_reg <= EXP_W'(64'd1 << FRAC);
                        k_reg     <= K_W'(1);
                        ret_reg   <= RET_NUM;
                        state_reg <= S_EXP_MUL;
                    end else begin
                        t_reg     <= (29'd1 << LOG_BITS) - {1'b0, e_val[27:0]};
                        state_reg <= S_Z_MUL;
                    end
                end
                S_Z_MUL: begin
                    state_reg <= S_Z_DONE;
                end
                S_Z_DONE: begin
                    x_reg     <= {1'b0, prod_reg[57:28]};
                    esum_reg  <= EXP_W'(64'd1 << FRAC);
                    eterm_reg <= EXP_W'(64'd1 << FRAC);
                    k_reg     <= K_W'(1);
                    ret_reg   <= RET_POW;
                    state_reg <= S_EXP_MUL;
                end
                S_EXP_MUL: begin
                    state_reg <= S_EXP_DIV;
                end
                S_EXP_DIV: begin
                    state_reg <= S_EXP_WAIT;
                end
                S_EXP_WAIT: begin
                    if (div_rsp.done) begin
                        if (!exp_fin) begin
                            esum_reg  <= esum_new;
                            eterm_reg <= div_rsp.quotient[EXP_W-1:0];
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_EXP_MUL;
                        end else begin
                            esum_reg  <= EXP_W'(64'd1 << FRAC);
                            eterm_reg <= EXP_W'(64'd1 << FRAC);
                            k_reg     <= K_W'(1);
                            case (ret_reg)
                                RET_POW: begin
                                    x_reg     <= 31'(esum_new >> ({1'b0, n_reg} + 6'd1));
                                    ret_reg   <= RET_NUM;
                                    state_reg <= S_EXP_MUL;
                                end
                                RET_NUM: begin
                                    num_reg   <= esum_new;
                                    x_reg     <= total_reg;
                                    ret_reg   <= RET_DEN;
                                    state_reg <= S_EXP_MUL;
                                end
                                default: begin
                                    den_reg   <= {1'b0, beta_reg, 14'd0} + DEN_W'(esum_new);
                                    state_reg <= S_Q_MUL;
                                end
                            endcase
                        end
                    end
                end
                S_Q_MUL: begin
                    state_reg <= S_Q_DIV;
                end
                S_Q_DIV: begin
                    state_reg <= S_Q_WAIT;
                end
                S_Q_WAIT: begin
                    if (div_rsp.done) begin
                        term_reg  <= div_rsp.quotient;
                        state_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (!last_reg) begin
                        running_sum_reg <= acc_ovf ? '1 : acc_sum[SUM_W-1:0];
                        sat_flag_reg    <= sat_flag_reg | acc_ovf;
                        state_reg       <= S_IDLE;
                    end else if (out_free) begin
                        // Emit the finished distance and start a new one.
                        out_dist_reg    <= acc_ovf ? '1 : acc_sum[SUM_W-1:0];
                        out_ovf_reg     <= sat_flag_reg | acc_ovf;
                        m_valid_reg     <= 1'b1;
                        running_sum_reg <= '0;
                        sat_flag_reg    <= 1'b0;
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `WER_ASSERT_NEXT(a_clear_on_last, state_reg == S_ACC && last_reg && out_free, running_sum_reg == '0 && !sat_flag_reg && m_valid_reg, "sum not cleared after emit")

endmodule

FILE: src/weighted_exp_ratio_distance.sv
// Weighted exponential-ratio distance: each accepted word carries a pair of Q0.16
// probabilities and a Q8.8 weight, and the term w*exp(|a-b|^alpha)/(beta+exp(a+b)) is
// added to a saturating Q24.16 sum; the word marked last produces one result word with
// the sum and the overflow flag, and the sum starts over. A front stage forms |a-b| and
// a+b and places the pair in a two-entry queue, so input words keep being taken while
// the back engine works, until the queue is full. The back engine handles one pair at a
// time: its cost is set by one shared bit-serial divider, used once per series term of
// each of up to three exponentials and once for the final quotient, and by the
// log-by-squaring of |a-b| after it is normalized. Configuration is written through
// cfg_wr_en, cfg_addr (0 alpha_exponent, 1 beta_offset) and cfg_wdata; the user must
// write it only while the block is idle, as the block itself does not enforce this.
module weighted_exp_ratio_distance import wer_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // value_a, value_b, term_weight
    input  logic                  s_tlast,   // last_pair
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata    // distance, overflowed
);

    logic      push_valid;
    logic      push_ready;
    wer_item_t push_data;
    logic      pop_valid;
    logic      pop_ready;
    wer_item_t pop_data;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    // Front: unpack and classify each word.
    wer_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data)
    );

    // Queue between front and back.
    wer_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data)
    );

    // Back: term evaluation and accumulation.
    wer_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .q_valid  (pop_valid),
        .q_ready  (pop_ready),
        .q_data   (pop_data),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shared bit-serial divider.
    wer_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

endmodule
